// ===== hdl/elc_pkg.sv =====
package elc_pkg;

    localparam int ELC_FLOORS = 10;

    localparam int FLOOR_W    = 4;
    localparam int LOAD_W     = 4;
    localparam int TIME_W     = 32;
    localparam int PASS_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [FLOOR_W-1:0]    t_floor;
    typedef logic [LOAD_W-1:0]     t_load;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [PASS_W-1:0]     t_pass;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FLOOR = 2'd0,
        CFG_CAPACITY    = 2'd1,
        CFG_TOTAL       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_cmd   command;
        t_floor from_floor;
        t_floor to_floor;
    } t_req;

endpackage

// ===== hdl/elc_req_if.sv =====
interface elc_req_if;
    import elc_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   command;
    t_floor from_floor;
    t_floor to_floor;

    modport source (output valid, output command, output from_floor, output to_floor,
                    input ready);
    modport sink (input valid, input command, input from_floor, input to_floor,
                  output ready);
endinterface

// ===== hdl/elc_res_if.sv =====
interface elc_res_if;
    import elc_pkg::*;

    logic   valid;
    logic   ready;
    t_floor stop_floor;
    t_time  stop_time;
    t_load  load_after;

    modport source (output valid, output stop_floor, output stop_time, output load_after,
                    input ready);
    modport sink (input valid, input stop_floor, input stop_time, input load_after,
                  output ready);
endinterface

// ===== hdl/elc_in_reg.sv =====
module elc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    elc_req_if.sink       i_req,
    input  logic          i_take,
    output logic          o_valid,
    output elc_pkg::t_req o_req
);
    import elc_pkg::*;

    logic r_valid;
    t_req r_req;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.command    <= i_req.command;
            r_req.from_floor <= i_req.from_floor;
            r_req.to_floor   <= i_req.to_floor;
        end
    end
endmodule

// ===== hdl/elc_core.sv =====
module elc_core #(
    parameter int FLOORS = elc_pkg::ELC_FLOORS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [elc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  elc_pkg::t_cfg_data                   i_cfg_data,
    input  logic                                 i_valid,
    input  elc_pkg::t_req                        i_req,
    output logic                                 o_take,
    elc_res_if.source                            o_res
);
    import elc_pkg::*;

    localparam t_floor TOP_FLOOR = t_floor'(FLOORS);
    localparam t_floor BOTTOM    = t_floor'(1);
    localparam t_load  LOAD_MAX  = '1;

    // car state
    t_floor r_car_floor;
    logic   r_going_up;
    t_time  r_tick_count;
    t_load  r_riders;
    t_pass  r_remaining;
    t_load  r_capacity;
    logic   [FLOORS:1] r_wait_valid;
    t_floor r_wait_dest [1:FLOORS];
    t_load  r_bound [1:FLOORS];

    // result register
    logic   r_out_valid;
    t_floor r_out_floor;
    t_time  r_out_time;
    t_load  r_out_load;

    logic   fl_ok, tick_go, arr_go, leave, board, stopped, pending, ahead, dir_next;
    t_floor fl, dest;
    t_load  bound_here, riders_al, riders_new;
    t_pass  rem_new;
    t_floor car_next;
    logic   [FLOORS:1] wait_new, work;
    t_load  bound_new [1:FLOORS];

    assign o_take = i_valid && (!r_out_valid || o_res.ready);

    assign o_res.valid      = r_out_valid;
    assign o_res.stop_floor = r_out_floor;
    assign o_res.stop_time  = r_out_time;
    assign o_res.load_after = r_out_load;

    always_comb begin
        fl      = r_car_floor;
        fl_ok   = (fl >= BOTTOM) && (fl <= TOP_FLOOR);
        tick_go = o_take && (i_req.command == CMD_TICK) && (r_remaining != '0) && fl_ok;
        arr_go  = o_take && (i_req.command == CMD_ARRIVE)
                  && (i_req.from_floor >= BOTTOM) && (i_req.from_floor <= TOP_FLOOR)
                  && (i_req.to_floor >= BOTTOM) && (i_req.to_floor <= TOP_FLOOR);

        bound_here = fl_ok ? r_bound[fl] : '0;
        dest       = fl_ok ? r_wait_dest[fl] : '0;
        leave      = bound_here != '0;
        riders_al  = (r_riders > bound_here) ? t_load'(r_riders - bound_here) : '0;
        rem_new    = (r_remaining > t_pass'(bound_here))
                     ? t_pass'(r_remaining - t_pass'(bound_here)) : '0;
        board      = fl_ok && r_wait_valid[fl] && (riders_al < r_capacity);
        riders_new = board ? t_load'(riders_al + t_load'(1)) : riders_al;
        stopped    = leave || board;

        // per-floor state after serving the current floor
        for (int j = 1; j <= FLOORS; j++) begin
            wait_new[j]  = r_wait_valid[j] && !(board && (fl == t_floor'(j)));
            bound_new[j] = (leave && (fl == t_floor'(j))) ? '0 : r_bound[j];
            if (board && (dest == t_floor'(j)) && (bound_new[j] != LOAD_MAX)) begin
                bound_new[j] = t_load'(bound_new[j] + t_load'(1));
            end
            work[j] = (wait_new[j] && (riders_new < r_capacity)) || (bound_new[j] != '0);
        end

        pending = |work;
        ahead   = 1'b0;
        for (int j = 1; j <= FLOORS; j++) begin
            if (work[j] && (r_going_up ? (t_floor'(j) > fl) : (t_floor'(j) < fl))) begin
                ahead = 1'b1;
            end
        end

        dir_next = ahead ? r_going_up : !r_going_up;
        if (fl == BOTTOM) begin
            dir_next = 1'b1;
        end
        if (fl == TOP_FLOOR) begin
            dir_next = 1'b0;
        end
        car_next = dir_next ? t_floor'(fl + t_floor'(1)) : t_floor'(fl - t_floor'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_floor  <= BOTTOM;
            r_going_up   <= 1'b1;
            r_tick_count <= '0;
            r_riders     <= '0;
            r_remaining  <= '0;
            r_capacity   <= t_load'(4);
            r_wait_valid <= '0;
            for (int j = 1; j <= FLOORS; j++) begin
                r_bound[j] <= '0;
            end
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_FLOOR: r_car_floor <= i_cfg_data[FLOOR_W-1:0];
                    CFG_CAPACITY:    r_capacity  <= i_cfg_data[LOAD_W-1:0];
                    CFG_TOTAL:       r_remaining <= i_cfg_data[PASS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (arr_go) begin
                r_wait_valid[i_req.from_floor] <= 1'b1;
            end

            if (tick_go) begin
                r_riders     <= riders_new;
                r_remaining  <= rem_new;
                r_wait_valid <= wait_new;
                r_tick_count <= r_tick_count + t_time'(1);
                for (int j = 1; j <= FLOORS; j++) begin
                    r_bound[j] <= bound_new[j];
                end
                if (pending) begin
                    r_going_up  <= dir_next;
                    r_car_floor <= car_next;
                end
            end

            if (o_take) begin
                r_out_valid <= tick_go && stopped;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (arr_go) begin
            r_wait_dest[i_req.from_floor] <= i_req.to_floor;
        end
        if (o_take) begin
            r_out_floor <= fl;
            r_out_time  <= r_tick_count;
            r_out_load  <= riders_new;
        end
    end
endmodule

// ===== hdl/elevator_look_controller.sv =====
// channel   dir  payload                               handshake
// i_req     in   command, from_floor, to_floor         valid/ready
// o_res     out  stop_floor, stop_time, load_after     valid/ready
// i_cfg_*   in   register index, write data            write enable, no wait
//
// one request per cycle while no stop report waits unread; a request waits in the input
// register until the core takes it; its stop report, if any, is registered on that edge
// the whole tick (leave, board, pending scan over all floors, next floor) is one
// combinational pass from the car state, so the rate is one request a cycle
// reset restores the power-on register values; while a report waits unread the core
// takes nothing, so the input register fills with one request and then holds it
module elevator_look_controller #(
    parameter int FLOORS = elc_pkg::ELC_FLOORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [elc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  elc_pkg::t_cfg_data            i_cfg_data,
    elc_req_if.sink                       i_req,
    elc_res_if.source                     o_res
);
    import elc_pkg::*;

    logic take;
    logic req_valid;
    t_req req;

    elc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (req_valid),
        .o_req   (req)
    );

    elc_core #(
        .FLOORS (FLOORS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (req_valid),
        .i_req      (req),
        .o_take     (take),
        .o_res      (o_res)
    );
endmodule

// ===== sim/elevator_look_controller_tb.sv =====
module elevator_look_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import elc_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_CYC  = 8;
    localparam int RAND_PHASES = 8;
    localparam int RAND_ITEMS  = 205;

    typedef struct packed {
        t_floor floor_no;
        t_time  at_tick;
        t_load  load;
    } t_stop;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_cfg_data            cfg_data;

    elc_req_if req_ch ();
    elc_res_if res_ch ();

    elevator_look_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // car model state
    t_floor m_start;
    t_load  m_capacity;
    t_pass  m_total;
    t_floor m_floor;
    bit     m_up;
    t_time  m_ticks;
    t_load  m_load;
    t_pass  m_remaining;
    bit     m_wait_valid [16];
    t_floor m_wait_dest  [16];
    t_load  m_bound      [16];

    t_req  request_q [$];
    t_stop stop_q    [$];

    int errors;
    int items_queued;
    int reqs_accepted;
    int ticks_accepted;
    int stops_seen;
    int settings_used;
    int gap_left;
    int burst_left;
    int idle_cycles;
    logic [9:0] stall_cycle;

    function automatic bit floor_has_work(input int f);
        return (m_wait_valid[f] && m_load < m_capacity) || m_bound[f] != 0;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input int unsigned val);
        case (idx)
            CFG_START_FLOOR: begin
                m_start = val[FLOOR_W-1:0];
                m_floor = m_start;
            end
            CFG_CAPACITY: m_capacity = val[LOAD_W-1:0];
            CFG_TOTAL: begin
                m_total     = val[PASS_W-1:0];
                m_remaining = m_total;
            end
            default: ;
        endcase
    endfunction

    // one request through the car: returns 1 when the car stops with a report
    function automatic bit car_step(input t_req r, output t_stop st);
        t_floor fl;
        t_load  b;
        t_floor d;
        bit     stopped;
        bit     pending;
        bit     ahead;
        fl      = m_floor;
        stopped = 1'b0;
        pending = 1'b0;
        ahead   = 1'b0;
        st      = '0;
        if (r.command == CMD_ARRIVE) begin
            if (r.from_floor >= 1 && r.from_floor <= ELC_FLOORS &&
                r.to_floor >= 1 && r.to_floor <= ELC_FLOORS) begin
                m_wait_valid[r.from_floor] = 1'b1;
                m_wait_dest[r.from_floor]  = r.to_floor;
            end
            return 1'b0;
        end
        if (m_remaining == 0 || fl < 1 || fl > ELC_FLOORS)
            return 1'b0;
        if (m_bound[fl] != 0) begin
            b           = m_bound[fl];
            stopped     = 1'b1;
            m_load      = (m_load > b) ? m_load - b : '0;
            m_remaining = (m_remaining > b) ? m_remaining - b : '0;
            m_bound[fl] = '0;
        end
        if (m_wait_valid[fl] && m_load < m_capacity) begin
            d       = m_wait_dest[fl];
            stopped = 1'b1;
            m_load  = m_load + 1'b1;
            if (m_bound[d] < 15)
                m_bound[d] = m_bound[d] + 1'b1;
            m_wait_valid[fl] = 1'b0;
        end
        if (stopped)
            st = '{floor_no: fl, at_tick: m_ticks, load: m_load};
        for (int j = 1; j <= ELC_FLOORS; j++)
            if (floor_has_work(j))
                pending = 1'b1;
        if (pending) begin
            for (int j = 1; j <= ELC_FLOORS; j++) begin
                if (m_up && j > fl && floor_has_work(j))
                    ahead = 1'b1;
                if (!m_up && j < fl && floor_has_work(j))
                    ahead = 1'b1;
            end
            if (!ahead)
                m_up = !m_up;
            if (fl == 1)
                m_up = 1'b1;
            if (fl == ELC_FLOORS)
                m_up = 1'b0;
            m_floor = m_up ? fl + 1'b1 : fl - 1'b1;
        end
        m_ticks = m_ticks + 1'b1;
        return stopped;
    endfunction

    always #2 i_clk = ~i_clk;

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin : drive_req
        t_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left     <= 0;
            burst_left   <= 1;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
                req_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (request_q.size() != 0) begin
                nxt = request_q.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.command    <= nxt.command;
                req_ch.from_floor <= nxt.from_floor;
                req_ch.to_floor   <= nxt.to_floor;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver stalls on a rotating pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_cycle  <= '0;
        end else begin
            stall_cycle <= stall_cycle + 1'b1;
            case (stall_cycle[9:8])
                2'd0: res_ch.ready <= 1'b1;
                2'd1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2: res_ch.ready <= (stall_cycle[2:0] == 3'd0);
                default: res_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // monitor: check reports against the oldest expected stop, predict on each request
    always @(posedge i_clk) begin : watch
        t_stop got;
        t_stop want;
        t_stop pred;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                stops_seen++;
                got = '{floor_no: res_ch.stop_floor, at_tick: res_ch.stop_time,
                        load: res_ch.load_after};
                if (stop_q.size() == 0) begin
                    $display("%0t: unexpected stop, expected none, got %0d/%0d/%0d",
                             $realtime, got.floor_no, got.at_tick, got.load);
                    errors++;
                end else begin
                    want = stop_q.pop_front();
                    if (got.floor_no !== want.floor_no) begin
                        $display("%0t: stop_floor mismatch, expected %0d, got %0d",
                                 $realtime, want.floor_no, got.floor_no);
                        errors++;
                    end
                    if (got.at_tick !== want.at_tick) begin
                        $display("%0t: stop_time mismatch, expected %0d, got %0d",
                                 $realtime, want.at_tick, got.at_tick);
                        errors++;
                    end
                    if (got.load !== want.load) begin
                        $display("%0t: load_after mismatch, expected %0d, got %0d",
                                 $realtime, want.load, got.load);
                        errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                reqs_accepted++;
                if (req_ch.command == CMD_TICK)
                    ticks_accepted++;
                if (car_step('{command: req_ch.command, from_floor: req_ch.from_floor,
                               to_floor: req_ch.to_floor}, pred))
                    stop_q.push_back(pred);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or report moved for %0d cycles", $realtime, idle_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic set_car(input int unsigned start, input int unsigned cap,
                           input int unsigned total);
        write_reg(CFG_START_FLOOR, start);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_TOTAL, total);
        settings_used++;
    endtask

    task automatic queue_item(input t_cmd cmd, input int unsigned src, input int unsigned dst);
        request_q.push_back('{command: cmd, from_floor: src[FLOOR_W-1:0],
                              to_floor: dst[FLOOR_W-1:0]});
        items_queued++;
    endtask

    // sender holds off until every request is in and every stop report is out
    task automatic drain();
        do @(negedge i_clk);
        while (reqs_accepted != items_queued || stop_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                queue_item(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 15));
            else if (r < 94)
                queue_item(CMD_ARRIVE, $urandom_range(1, ELC_FLOORS),
                           $urandom_range(1, ELC_FLOORS));
            else
                queue_item(CMD_ARRIVE, $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endtask

    initial begin
        int unsigned start;
        int unsigned cap;
        int unsigned total;

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_START_FLOOR;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_ARRIVE;
        req_ch.from_floor = '0;
        req_ch.to_floor   = '0;
        res_ch.ready      = 1'b0;
        errors            = 0;
        items_queued      = 0;
        reqs_accepted     = 0;
        ticks_accepted    = 0;
        stops_seen        = 0;
        settings_used     = 1;
        idle_cycles       = 0;

        m_start     = 1;
        m_capacity  = 4;
        m_total     = 0;
        m_floor     = m_start;
        m_up        = 1'b1;
        m_ticks     = '0;
        m_load      = '0;
        m_remaining = m_total;
        for (int f = 0; f < 16; f++) begin
            m_wait_valid[f] = 1'b0;
            m_wait_dest[f]  = '0;
            m_bound[f]      = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-on settings: nothing to deliver, so ticks do nothing
        queue_item(CMD_ARRIVE, 2, 9);
        queue_item(CMD_TICK, 0, 0);
        queue_item(CMD_TICK, 15, 15);
        drain();

        // single-seat car, overwrite at floor 1, out-of-range arrivals ignored
        set_car(1, 1, 8);
        queue_item(CMD_ARRIVE, 1, 10);
        queue_item(CMD_ARRIVE, 10, 1);
        queue_item(CMD_ARRIVE, 1, 5);
        queue_item(CMD_ARRIVE, 0, 3);
        queue_item(CMD_ARRIVE, 3, 0);
        queue_item(CMD_ARRIVE, 11, 4);
        queue_item(CMD_ARRIVE, 4, 15);
        queue_item(CMD_ARRIVE, 15, 15);
        queue_item(CMD_ARRIVE, 6, 6);
        repeat (9) queue_item(CMD_TICK, 0, 0);
        drain();

        // capacity zero from the top floor: nobody boards
        set_car(ELC_FLOORS, 0, 3);
        queue_item(CMD_ARRIVE, 10, 1);
        queue_item(CMD_ARRIVE, 9, 2);
        repeat (3) queue_item(CMD_TICK, 0, 0);
        drain();

        // car parked off the shaft: halted
        set_car(0, 15, 1023);
        queue_item(CMD_TICK, 0, 0);
        queue_item(CMD_TICK, 0, 0);
        drain();
        set_car(15, 15, 1023);
        queue_item(CMD_TICK, 0, 0);
        queue_item(CMD_TICK, 0, 0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            start = (ph == 0) ? 1 : (ph == 1) ? ELC_FLOORS : $urandom_range(1, ELC_FLOORS);
            cap   = (ph == 2) ? 15 : (ph == 3) ? 1 : $urandom_range(1, 15);
            total = (ph == 4) ? $urandom_range(3, 12) :
                    (ph == 5) ? 1023 : $urandom_range(100, 1023);
            set_car(start, cap, total);
            queue_random(RAND_ITEMS);
            drain();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("covered %0d requests (%0d ticks) and %0d stop reports", reqs_accepted,
                 ticks_accepted, stops_seen);
        $display("over %0d car settings, %0d mismatches", settings_used, errors);
        if (errors == 0 && stop_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
